// ===== src/rtkd_pkg.sv =====
// rtkd_pkg: shared types, widths, status codes and the small-prime table
// for the toy key derivation block; depends on nothing

package rtkd_pkg;

    localparam int FIELD_W    = 18;
    localparam int INDEX_W    = 7;
    localparam int PRIME_W    = 9;
    localparam int COEF_W     = 20;
    localparam int TABLE_SIZE = 66;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [PRIME_W-1:0] prime_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [1:0]         status_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_COPRIME = 2'd1;
    localparam status_t STATUS_EXP_ZERO  = 2'd2;
    localparam status_t STATUS_EXP_LARGE = 2'd3;

    // primes from 131 to 509, in order
    function automatic prime_t prime_lookup(input index_t idx);
        prime_t p;
        case (idx)
            7'd0:  p = 9'd131;  7'd1:  p = 9'd137;  7'd2:  p = 9'd139;
            7'd3:  p = 9'd149;  7'd4:  p = 9'd151;  7'd5:  p = 9'd157;
            7'd6:  p = 9'd163;  7'd7:  p = 9'd167;  7'd8:  p = 9'd173;
            7'd9:  p = 9'd179;  7'd10: p = 9'd181;  7'd11: p = 9'd191;
            7'd12: p = 9'd193;  7'd13: p = 9'd197;  7'd14: p = 9'd199;
            7'd15: p = 9'd211;  7'd16: p = 9'd223;  7'd17: p = 9'd227;
            7'd18: p = 9'd229;  7'd19: p = 9'd233;  7'd20: p = 9'd239;
            7'd21: p = 9'd241;  7'd22: p = 9'd251;  7'd23: p = 9'd257;
            7'd24: p = 9'd263;  7'd25: p = 9'd269;  7'd26: p = 9'd271;
            7'd27: p = 9'd277;  7'd28: p = 9'd281;  7'd29: p = 9'd283;
            7'd30: p = 9'd293;  7'd31: p = 9'd307;  7'd32: p = 9'd311;
            7'd33: p = 9'd313;  7'd34: p = 9'd317;  7'd35: p = 9'd331;
            7'd36: p = 9'd337;  7'd37: p = 9'd347;  7'd38: p = 9'd349;
            7'd39: p = 9'd353;  7'd40: p = 9'd359;  7'd41: p = 9'd367;
            7'd42: p = 9'd373;  7'd43: p = 9'd379;  7'd44: p = 9'd383;
            7'd45: p = 9'd389;  7'd46: p = 9'd397;  7'd47: p = 9'd401;
            7'd48: p = 9'd409;  7'd49: p = 9'd419;  7'd50: p = 9'd421;
            7'd51: p = 9'd431;  7'd52: p = 9'd433;  7'd53: p = 9'd439;
            7'd54: p = 9'd443;  7'd55: p = 9'd449;  7'd56: p = 9'd457;
            7'd57: p = 9'd461;  7'd58: p = 9'd463;  7'd59: p = 9'd467;
            7'd60: p = 9'd479;  7'd61: p = 9'd487;  7'd62: p = 9'd491;
            7'd63: p = 9'd499;  7'd64: p = 9'd503;  7'd65: p = 9'd509;
            default: p = 9'd509;
        endcase
        return p;
    endfunction

endpackage

// ===== src/rsa_toy_key_derivation.sv =====
// rsa_toy_key_derivation: toy rsa key derivation over a table of small primes
// depends on rtkd_pkg (widths, status codes, prime table)
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+-------------------------------------------
//  in      | into      | in_valid / in_stall  | first_prime_index, second_prime_index,
//          |           |                    | exponent_candidate
//  out     | out of    | out_valid / out_stall| modulus, totient, public_exponent,
//          |           |                    | private_exponent, status
//
// one item at a time; an item whose exponent is rejected early goes from
// S_PRODUCT through S_CHECK to S_EMIT, otherwise it runs k euclid rounds
// (k at most about 26) of S_TEST, S_DIV, S_MULT and S_UPDATE, then S_FINAL and
// S_EMIT; the 18-step restoring divider is shared by every euclid round
// in_stall is high from acceptance until the result is loaded into the output
// register; a result held by out_stall does not block the next item
// reset is asynchronous and clears all control state; no clearing pass

module rsa_toy_key_derivation
    import rtkd_pkg::*;
#(
    parameter int PRIME_COUNT = 66
)(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  index_t first_prime_index,
    input  index_t second_prime_index,
    input  field_t exponent_candidate,
    output logic   out_valid,
    input  logic   out_stall,
    output field_t modulus,
    output field_t totient,
    output field_t public_exponent,
    output field_t private_exponent,
    output status_t status
);

    // indices at or above the usable count saturate to the last usable entry
    localparam int     USABLE    = (PRIME_COUNT > TABLE_SIZE) ? TABLE_SIZE : PRIME_COUNT;
    localparam index_t LAST_IDX  = INDEX_W'(USABLE - 1);
    localparam int     DIV_STEPS = FIELD_W;
    localparam int     CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRODUCT,  // form n and the totient
        S_CHECK,    // zero, too large, then start euclid
        S_TEST,     // euclid loop test: r1 zero ends it
        S_DIV,      // one quotient bit a cycle
        S_MULT,     // quotient times t1
        S_UPDATE,   // shift the remainder and coefficient pairs
        S_FINAL,    // gcd check and sign fixup of d
        S_EMIT      // wait for the output register
    } state_t;

    state_t state_reg, state_next;

    prime_t p_reg, p_next, q_reg, q_next;
    field_t e_reg, e_next;
    field_t n_reg, n_next, fn_reg, fn_next;
    field_t r0_reg, r0_next, r1_reg, r1_next;
    coef_t  t0_reg, t0_next, t1_reg, t1_next, prod_reg, prod_next;
    field_t rem_reg, rem_next, quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    field_t  d_reg, d_next;
    status_t st_reg, st_next;

    logic    out_valid_reg, out_valid_next;
    field_t  modulus_reg, modulus_next, totient_reg, totient_next;
    field_t  pexp_reg, pexp_next, dout_reg, dout_next;
    status_t status_reg, status_next;

    index_t idx_a, idx_b;
    logic [FIELD_W:0]   shifted;
    logic [FIELD_W+1:0] diff;
    // |quotient * t1| stays below twice the totient, so the low bits hold it
    coef_t  prod_full;
    coef_t  t_plus_m;
    coef_t  t_minus_m;
    logic   out_free;

    always_comb begin
        idx_a = (first_prime_index  > LAST_IDX) ? LAST_IDX : first_prime_index;
        idx_b = (second_prime_index > LAST_IDX) ? LAST_IDX : second_prime_index;

        // restoring divider step on r0 / r1
        shifted   = {rem_reg, quo_reg[FIELD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, r1_reg};
        prod_full = $signed({2'b00, quo_reg}) * t1_reg;
        t_plus_m  = t0_reg + $signed({2'b00, fn_reg});
        t_minus_m = t0_reg - $signed({2'b00, fn_reg});
        out_free  = !out_valid_reg || !out_stall;
    end

    always_comb begin
        state_next     = state_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        e_next         = e_reg;
        n_next         = n_reg;
        fn_next        = fn_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        d_next         = d_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && out_stall;
        modulus_next   = modulus_reg;
        totient_next   = totient_reg;
        pexp_next      = pexp_reg;
        dout_next      = dout_reg;
        status_next    = status_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    p_next     = prime_lookup(idx_a);
                    q_next     = prime_lookup(idx_b);
                    e_next     = exponent_candidate;
                    state_next = S_PRODUCT;
                end
            end
            S_PRODUCT: begin
                n_next     = FIELD_W'(p_reg) * FIELD_W'(q_reg);
                fn_next    = FIELD_W'(p_reg - 9'd1) * FIELD_W'(q_reg - 9'd1);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                d_next = '0;
                if (e_reg == '0) begin
                    st_next    = STATUS_EXP_ZERO;
                    state_next = S_EMIT;
                end else if (e_reg >= fn_reg) begin
                    st_next    = STATUS_EXP_LARGE;
                    state_next = S_EMIT;
                end else begin
                    r0_next    = fn_reg;
                    r1_next    = e_reg;
                    t0_next    = '0;
                    t1_next    = COEF_W'(1);
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                if (r1_reg == '0) begin
                    state_next = S_FINAL;
                end else begin
                    rem_next   = '0;
                    quo_next   = r0_reg;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!diff[FIELD_W+1]) begin
                    rem_next = diff[FIELD_W-1:0];
                    quo_next = {quo_reg[FIELD_W-2:0], 1'b1};
                end else begin
                    rem_next = shifted[FIELD_W-1:0];
                    quo_next = {quo_reg[FIELD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_MULT;
                end
            end
            S_MULT: begin
                prod_next  = prod_full;
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                r0_next    = r1_reg;
                r1_next    = rem_reg;
                t0_next    = t1_reg;
                t1_next    = t0_reg - prod_reg;
                state_next = S_TEST;
            end
            S_FINAL: begin
                if (r0_reg != FIELD_W'(1)) begin
                    st_next = STATUS_NOT_COPRIME;
                    d_next  = '0;
                end else begin
                    st_next = STATUS_OK;
                    if (t0_reg < 0) begin
                        d_next = t_plus_m[FIELD_W-1:0];
                    end else if (!t_minus_m[COEF_W-1]) begin
                        d_next = t_minus_m[FIELD_W-1:0];
                    end else begin
                        d_next = t0_reg[FIELD_W-1:0];
                    end
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    modulus_next   = n_reg;
                    totient_next   = fn_reg;
                    pexp_next      = e_reg;
                    dout_next      = d_reg;
                    status_next    = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            p_reg         <= '0;
            q_reg         <= '0;
            e_reg         <= '0;
            n_reg         <= '0;
            fn_reg        <= '0;
            r0_reg        <= '0;
            r1_reg        <= '0;
            t0_reg        <= '0;
            t1_reg        <= '0;
            prod_reg      <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            d_reg         <= '0;
            st_reg        <= STATUS_OK;
            modulus_reg   <= '0;
            totient_reg   <= '0;
            pexp_reg      <= '0;
            dout_reg      <= '0;
            status_reg    <= STATUS_OK;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            p_reg         <= p_next;
            q_reg         <= q_next;
            e_reg         <= e_next;
            n_reg         <= n_next;
            fn_reg        <= fn_next;
            r0_reg        <= r0_next;
            r1_reg        <= r1_next;
            t0_reg        <= t0_next;
            t1_reg        <= t1_next;
            prod_reg      <= prod_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
            d_reg         <= d_next;
            st_reg        <= st_next;
            modulus_reg   <= modulus_next;
            totient_reg   <= totient_next;
            pexp_reg      <= pexp_next;
            dout_reg      <= dout_next;
            status_reg    <= status_next;
        end
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign modulus          = modulus_reg;
    assign totient          = totient_reg;
    assign public_exponent  = pexp_reg;
    assign private_exponent = dout_reg;
    assign status           = status_reg;

endmodule
